### sv/dmst_pkg.sv
// ----------------------------------------------------------------------------
// Score table package
// Shared types, field widths and codes of the direct-mapped score table.
// ----------------------------------------------------------------------------
package dmst_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned PLY_W   = 8;
  localparam int unsigned MOVE_W  = 16;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned BOUND_W = 2;
  localparam int unsigned MATE_W  = 15;

  localparam logic [MATE_W-1:0] MATE_BOUND_RESET = 15'd31000;

  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [BOUND_W-1:0] BOUND_NONE  = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;
  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic signed [DEPTH_W-1:0] depth;
    logic [BOUND_W-1:0]        bound;
  } slot_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_READ,
    ST_EVAL
  } state_t;

endpackage

### sv/dmst_index.sv
// ----------------------------------------------------------------------------
// Slot index unit
// Reduces a position hash modulo the table size. A power-of-two size is a
// plain bit slice; any other size is reduced four hash bits per cycle.
// ----------------------------------------------------------------------------
module dmst_index #(
  parameter int unsigned ENTRIES = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dmst_pkg::KEY_W-1:0]    hash,
  output logic                          done,
  output logic [$clog2(ENTRIES)-1:0]    index
);
  import dmst_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam bit          POW2  = (ENTRIES & (ENTRIES - 1)) == 0;

  generate
    if (POW2) begin : g_pow2
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          index <= hash[IDX_W-1:0];
        end
      end
    end else begin : g_serial
      localparam int unsigned STEP_BITS = 4;
      localparam int unsigned STEPS     = KEY_W / STEP_BITS;
      localparam int unsigned CNT_W     = $clog2(STEPS);
      localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(ENTRIES);

      logic [KEY_W-1:0] shift;
      logic [CNT_W-1:0] count;
      logic             busy;
      logic [IDX_W-1:0] rem_next;

      always_comb begin
        logic [IDX_W:0] t;
        rem_next = index;
        for (int i = 0; i < STEP_BITS; i++) begin
          t = {rem_next, shift[KEY_W-1-i]};
          if (t >= MODULUS) begin
            t = t - MODULUS;
          end
          rem_next = t[IDX_W-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          done <= 1'b0;
        end else if (start) begin
          busy <= 1'b1;
          done <= 1'b0;
        end else if (busy) begin
          if (count == CNT_W'(STEPS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          done <= 1'b0;
        end
        if (start) begin
          shift <= hash;
          index <= '0;
          count <= '0;
        end else if (busy) begin
          shift <= shift << STEP_BITS;
          index <= rem_next;
          count <= count + 1'b1;
        end
      end
    end
  endgenerate

endmodule

### sv/dmst_mate_adj.sv
// ----------------------------------------------------------------------------
// Mate score adjustment
// Moves a mate score away from zero by ply on store, or toward zero on load,
// saturating to the signed 16-bit range. Other scores pass unchanged.
// ----------------------------------------------------------------------------
module dmst_mate_adj (
  input  logic signed [dmst_pkg::SCORE_W-1:0] score,
  input  logic [dmst_pkg::PLY_W-1:0]          ply,
  input  logic [dmst_pkg::MATE_W-1:0]         mate_bound,
  input  logic                                to_table,
  output logic signed [dmst_pkg::SCORE_W-1:0] adjusted
);
  import dmst_pkg::*;

  localparam logic signed [SCORE_W+1:0] SAT_MAX = (SCORE_W + 2)'(32767);
  localparam logic signed [SCORE_W+1:0] SAT_MIN = -(SCORE_W + 2)'(32768);

  logic signed [SCORE_W:0]   wide;
  logic [SCORE_W:0]          mag;
  logic                      is_mate;
  logic                      positive;
  logic signed [SCORE_W+1:0] sum;
  logic signed [SCORE_W+1:0] ply_ext;

  always_comb begin
    wide     = {score[SCORE_W-1], score};
    mag      = score[SCORE_W-1] ? unsigned'(-wide) : unsigned'(wide);
    is_mate  = mag >= {2'b00, mate_bound};
    positive = !score[SCORE_W-1] && (score != '0);
    ply_ext  = signed'({{(SCORE_W + 2 - PLY_W){1'b0}}, ply});
    if (positive == to_table) begin
      sum = {{2{score[SCORE_W-1]}}, score} + ply_ext;
    end else begin
      sum = {{2{score[SCORE_W-1]}}, score} - ply_ext;
    end
    if (!is_mate) begin
      adjusted = score;
    end else if (sum > SAT_MAX) begin
      adjusted = SAT_MAX[SCORE_W-1:0];
    end else if (sum < SAT_MIN) begin
      adjusted = SAT_MIN[SCORE_W-1:0];
    end else begin
      adjusted = sum[SCORE_W-1:0];
    end
  end

endmodule

### sv/dmst_table.sv
// ----------------------------------------------------------------------------
// Slot memory
// Holds key and entry of every slot in one synchronous memory with a
// registered read, and sweeps it to zero after reset.
// ----------------------------------------------------------------------------
module dmst_table #(
  parameter int unsigned ENTRIES = 65536
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dmst_pkg::mem_req_t           req,
  input  logic [$clog2(ENTRIES)-1:0]   addr,
  input  dmst_pkg::slot_t              wdata,
  output dmst_pkg::slot_t              rdata,
  output logic                         busy
);
  import dmst_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  slot_t            mem [ENTRIES];
  logic [IDX_W-1:0] clr_addr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  slot_t            wd;

  always_comb begin
    if (busy) begin
      we    = 1'b1;
      waddr = clr_addr;
      wd    = '0;
    end else begin
      we    = req.wr;
      waddr = addr;
      wd    = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(ENTRIES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wd;
    end
    if (req.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

### sv/direct_mapped_score_table.sv
// ----------------------------------------------------------------------------
// Direct-mapped score table
// Always-replace table of search results keyed by a 64-bit position hash.
// Flow: an item passes the index, read and evaluate states, and a probe's
// result is then registered; the modulo unit holds the index state longer
// for sizes that are not a power of two, and a stalled result holds evaluate.
// One item at a time: no new item is taken until the last one leaves EVAL;
// each item makes one read and at most one write of the single slot memory.
// Reset: a sweep zeroes the memory; no input is taken then.
module direct_mapped_score_table #(
  parameter int unsigned ENTRIES = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dmst_pkg::MATE_W-1:0]   cfg_wdata,   // mate_bound
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // pos_hash, ply, best_move, search_depth, score_in, bound_kind, zero pad
  input  logic [119:0]                  s_tdata,
  input  logic [0:0]                    s_tuser,     // opcode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // move_out, score_out, depth_out, bound_out, zero pad
  output logic [47:0]                   m_tdata,
  output logic [0:0]                    m_tuser      // hit
);
  import dmst_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  state_t                    state;
  state_t                    state_next;
  logic [MATE_W-1:0]         mate_bound;
  logic                      op_q;
  logic [KEY_W-1:0]          hash_q;
  logic [PLY_W-1:0]          ply_q;
  logic [MOVE_W-1:0]         move_q;
  logic signed [DEPTH_W-1:0] depth_q;
  logic signed [SCORE_W-1:0] score_q;
  logic [BOUND_W-1:0]        bound_q;
  logic                      s_xfer;
  logic                      idx_done;
  logic [IDX_W-1:0]          idx;
  mem_req_t                  tbl_req;
  slot_t                     tbl_wdata;
  slot_t                     tbl_rdata;
  logic                      tbl_busy;
  logic signed [SCORE_W-1:0] score_store;
  logic signed [SCORE_W-1:0] score_load;
  logic                      key_match;
  logic                      hit;
  logic                      out_free;
  logic                      out_load;

  assign s_xfer   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  dmst_index #(.ENTRIES(ENTRIES)) u_index (
    .clk   (clk),
    .rst   (rst),
    .start (s_xfer),
    .hash  (s_tdata[63:0]),
    .done  (idx_done),
    .index (idx)
  );

  dmst_table #(.ENTRIES(ENTRIES)) u_table (
    .clk   (clk),
    .rst   (rst),
    .req   (tbl_req),
    .addr  (idx),
    .wdata (tbl_wdata),
    .rdata (tbl_rdata),
    .busy  (tbl_busy)
  );

  dmst_mate_adj u_adj_store (
    .score      (score_q),
    .ply        (ply_q),
    .mate_bound (mate_bound),
    .to_table   (1'b1),
    .adjusted   (score_store)
  );

  dmst_mate_adj u_adj_load (
    .score      (tbl_rdata.score),
    .ply        (ply_q),
    .mate_bound (mate_bound),
    .to_table   (1'b0),
    .adjusted   (score_load)
  );

  assign key_match = tbl_rdata.key == hash_q;
  assign hit       = key_match && (tbl_rdata.bound != BOUND_NONE);

  always_comb begin
    tbl_wdata.key   = hash_q;
    tbl_wdata.move  = ((move_q == '0) && key_match) ? tbl_rdata.move : move_q;
    tbl_wdata.score = score_store;
    tbl_wdata.depth = depth_q;
    tbl_wdata.bound = bound_q;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (!tbl_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_INDEX;
        end
      end
      ST_INDEX: begin
        if (idx_done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (op_q == OP_WRITE || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    tbl_req.rd = 1'b0;
    tbl_req.wr = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_READ: begin
        tbl_req.rd = 1'b1;
      end
      ST_EVAL: begin
        tbl_req.wr = op_q == OP_WRITE;
        out_load   = (op_q == OP_PROBE) && out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      mate_bound <= MATE_BOUND_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        mate_bound <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      op_q    <= s_tuser[0];
      hash_q  <= s_tdata[63:0];
      ply_q   <= s_tdata[71:64];
      move_q  <= s_tdata[87:72];
      depth_q <= s_tdata[95:88];
      score_q <= s_tdata[111:96];
      bound_q <= s_tdata[113:112];
    end
    if (out_load) begin
      m_tuser[0] <= hit;
      if (hit) begin
        m_tdata <= {6'b0, tbl_rdata.bound, tbl_rdata.depth, score_load, tbl_rdata.move};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

### sv/dmst_checker.sv
// ----------------------------------------------------------------------------
// Score table port checker
// Watches the ports of the score table and flags illegal result sequences.
// ----------------------------------------------------------------------------
module dmst_checker (
  input logic         clk,
  input logic         rst,
  input logic         cfg_we,
  input logic [14:0]  cfg_wdata,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [119:0] s_tdata,
  input logic [0:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [47:0]  m_tdata,
  input logic [0:0]   m_tuser
);
  import dmst_pkg::*;

  // The memory sweep keeps both channels quiet right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("channel active in the cycle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("miss result carries a nonzero payload");

  a_hit_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[41:40] != BOUND_NONE)
    else $error("hit result with bound none");

  // No result can appear in the cycle after an input transfer.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared too soon after an input transfer");

endmodule

bind direct_mapped_score_table dmst_checker u_dmst_checker (.*);
